// ===== hw/rtl/frnn_pkg.sv =====
// ----------------------------------------------------------------------------
// frnn_pkg
// Shared types, widths and request codes of the fixed radius neighbor search.
// ----------------------------------------------------------------------------
package frnn_pkg;

  // store size and coordinate width
  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;

  // field widths
  localparam int ID_W  = 32;
  localparam int RAD_W = 34;
  localparam int REQ_W = 2;

  // derived widths
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SQ_W       = 2 * COORD_BITS + 1;
  localparam int SUM_W      = SQ_W + 2;
  localparam int CMP_W      = (SUM_W > RAD_W) ? SUM_W : RAD_W;
  localparam int PIPE_DEPTH = 3;
  localparam int STEP_W     = $clog2(MAX_POINTS + PIPE_DEPTH);

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [ID_W-1:0]              id_t;

  // one stored reference point
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    id_t    id;
  } point_t;

  // result of the distance unit for one stored point
  typedef struct packed {
    logic valid;
    logic hit;
    id_t  id;
  } dist_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } frnn_state_t;

endpackage

// ===== hw/rtl/frnn_if.sv =====
// ----------------------------------------------------------------------------
// frnn_if
// Channel interfaces: request input, result output and radius write port.
// ----------------------------------------------------------------------------
interface frnn_in_if
  import frnn_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  coord_t           coord_x;
  coord_t           coord_y;
  coord_t           coord_z;
  id_t              point_id;

  modport source (output valid, req_type, coord_x, coord_y, coord_z, point_id,
                  input ready);
  modport sink (input valid, req_type, coord_x, coord_y, coord_z, point_id,
                output ready);
endinterface

interface frnn_out_if
  import frnn_pkg::*;
  ();
  logic valid;
  logic ready;
  id_t  match_id;
  logic found;
  logic last;

  modport source (output valid, match_id, found, last, input ready);
  modport sink (input valid, match_id, found, last, output ready);
endinterface

interface frnn_cfg_if
  import frnn_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [RAD_W-1:0] radius_squared;

  modport source (output valid, radius_squared, input ready);
  modport sink (input valid, radius_squared, output ready);
endinterface

// ===== hw/rtl/frnn_cell.sv =====
// ----------------------------------------------------------------------------
// frnn_cell
// One storage cell of the reference ring: loads a new point or takes the
// point of its neighbor while the ring rotates.
// ----------------------------------------------------------------------------
module frnn_cell
  import frnn_pkg::*;
(
  input  logic   clk,
  input  logic   ld_en,
  input  point_t ld_point,
  input  logic   shift_en,
  input  point_t shift_in,
  output point_t point_out
);

  point_t point_r;

  // load has priority, loads and rotation never overlap
  always_ff @(posedge clk) begin
    if (ld_en) begin
      point_r <= ld_point;
    end else if (shift_en) begin
      point_r <= shift_in;
    end
  end

  assign point_out = point_r;

endmodule

// ===== hw/rtl/frnn_dist.sv =====
// ----------------------------------------------------------------------------
// frnn_dist
// Three stage squared distance unit: differences, squares, sum; the radius
// compare is done on the sum register.
// ----------------------------------------------------------------------------
module frnn_dist
  import frnn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             src_valid,
  input  point_t           src_point,
  input  coord_t           qry_x,
  input  coord_t           qry_y,
  input  coord_t           qry_z,
  input  logic [RAD_W-1:0] radius,
  output dist_res_t        res
);

  logic                     v1_r, v2_r, v3_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [PROD_W-1:0] px, py, pz;
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  id_t                      id1_r, id2_r, id3_r;

  // sign-extended differences
  assign dx_nxt = {qry_x[COORD_BITS-1], qry_x} - {src_point.x[COORD_BITS-1], src_point.x};
  assign dy_nxt = {qry_y[COORD_BITS-1], qry_y} - {src_point.y[COORD_BITS-1], src_point.y};
  assign dz_nxt = {qry_z[COORD_BITS-1], qry_z} - {src_point.z[COORD_BITS-1], src_point.z};

  // squares are never negative
  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  assign sum_nxt = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= src_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      dz_r  <= dz_nxt;
      id1_r <= src_point.id;
      sqx_r <= px[SQ_W-1:0];
      sqy_r <= py[SQ_W-1:0];
      sqz_r <= pz[SQ_W-1:0];
      id2_r <= id1_r;
      sum_r <= sum_nxt;
      id3_r <= id2_r;
    end
  end

  // strict compare against the radius
  assign res.valid = v3_r;
  assign res.hit   = v3_r && (CMP_W'(sum_r) < CMP_W'(radius));
  assign res.id    = id3_r;

endmodule

// ===== hw/rtl/fixed_radius_neighbor_search.sv =====
// ----------------------------------------------------------------------------
// fixed_radius_neighbor_search
// Fixed radius near neighbor search over a ring of stored 3-D points.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   req_type, coord_x, coord_y, coord_z, point_id
//  out_chan  out  valid/ready   match_id, found, last
//  cfg_chan  in   valid/ready   radius_squared
//
//  a query rotates the point ring once past a single distance unit (three
//  stages), then the held last result is sent.
//  output stalls freeze the ring and the distance pipeline.
//  reset empties the store and zeroes the radius; no new request during a query.
// ----------------------------------------------------------------------------
module fixed_radius_neighbor_search
  import frnn_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  frnn_in_if.sink   in_chan,
  frnn_out_if.source out_chan,
  frnn_cfg_if.sink  cfg_chan
);

  frnn_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RAD_W-1:0] radius_r;
  coord_t           qx_r, qy_r, qz_r, qx_nxt, qy_nxt, qz_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  id_t              pend_id_r, pend_id_nxt;
  logic             out_valid_r, out_valid_nxt;
  id_t              out_id_r, out_id_nxt;
  logic             out_found_r, out_found_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_fire, load_fire, out_free, adv, shift_en, src_valid;
  point_t           ld_point;
  point_t           cell_q [MAX_POINTS];
  dist_res_t        res;

  localparam logic [STEP_W-1:0] SCAN_END  = STEP_W'(MAX_POINTS + PIPE_DEPTH - 1);
  localparam logic [STEP_W-1:0] RING_LEN  = STEP_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0]  STORE_MAX = CNT_W'(MAX_POINTS);

  // handshakes
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign load_fire = in_fire && (in_chan.req_type == REQ_LOAD) && (count_r < STORE_MAX);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign adv       = (state_r == ST_SCAN) && out_free;
  assign shift_en  = adv && (step_r < RING_LEN);
  assign src_valid = step_r < STEP_W'(count_r);

  assign ld_point.x  = in_chan.coord_x;
  assign ld_point.y  = in_chan.coord_y;
  assign ld_point.z  = in_chan.coord_z;
  assign ld_point.id = in_chan.point_id;

  // ring of point cells, cell 0 feeds the distance unit
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    frnn_cell u_cell (
      .clk      (clk),
      .ld_en    (load_fire && (count_r == CNT_W'(k))),
      .ld_point (ld_point),
      .shift_en (shift_en),
      .shift_in (cell_q[(k + 1) % MAX_POINTS]),
      .point_out(cell_q[k])
    );
  end

  frnn_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .src_valid(src_valid),
    .src_point(cell_q[0]),
    .qry_x    (qx_r),
    .qry_y    (qy_r),
    .qry_z    (qz_r),
    .radius   (radius_r),
    .res      (res)
  );

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      radius_r <= cfg_chan.radius_squared;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    qx_r        <= qx_nxt;
    qy_r        <= qy_nxt;
    qz_r        <= qz_nxt;
    pend_id_r   <= pend_id_nxt;
    out_id_r    <= out_id_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  // sequencer: one hit is held back until the next one shows whether it is last
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    qz_nxt         = qz_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_id_nxt     = out_id_r;
    out_found_nxt  = out_found_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.req_type)
            REQ_LOAD: begin
              if (count_r < STORE_MAX) begin
                count_nxt = count_r + 1'b1;
              end
            end
            REQ_QUERY: begin
              qx_nxt         = in_chan.coord_x;
              qy_nxt         = in_chan.coord_y;
              qz_nxt         = in_chan.coord_z;
              step_nxt       = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = ST_SCAN;
            end
            REQ_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (adv) begin
          step_nxt = step_r + 1'b1;
          if (res.hit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_id_nxt    = pend_id_r;
              out_found_nxt = 1'b1;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = res.id;
          end
          if (step_r == SCAN_END) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = pend_valid_r ? pend_id_r : '0;
          out_found_nxt = pend_valid_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  assign out_chan.valid    = out_valid_r;
  assign out_chan.match_id = out_id_r;
  assign out_chan.found    = out_found_r;
  assign out_chan.last     = out_last_r;

endmodule

// ===== hw/rtl/frnn_checker.sv =====
// ----------------------------------------------------------------------------
// frnn_checker
// Port level checks of the neighbor search, bound to the top level.
// ----------------------------------------------------------------------------
module frnn_checker
  import frnn_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [REQ_W-1:0] in_req_type,
  input logic             out_valid,
  input logic             out_ready,
  input id_t              out_match_id,
  input logic             out_found,
  input logic             out_last
);

  // a no-match result always closes the run
  a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found || out_last))
    else $error("no-match result without last");

  // a no-match result carries a zero identifier
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_id == '0))
    else $error("no-match result with nonzero id");

  // a query request blocks the input while it runs
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == REQ_QUERY)) |=> !in_ready)
    else $error("input ready during a query");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_match_id)
                                   && $stable(out_found) && $stable(out_last)))
    else $error("stalled result changed");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fixed_radius_neighbor_search frnn_checker u_frnn_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_req_type (in_chan.req_type),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_match_id(out_chan.match_id),
  .out_found   (out_chan.found),
  .out_last    (out_chan.last)
);
